// ===== sv/sparse_polynomial_adder_assert.svh =====
// Assertion macros for the sparse polynomial adder checker.
// No dependencies; included by files that carry assertions.
`ifndef SPARSE_POLYNOMIAL_ADDER_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ADDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sparse_polynomial_adder: assertion failed");

// Next-cycle implication, disabled during reset.
`define SPA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sparse_polynomial_adder: assertion failed");

`endif

// ===== sv/spa_pkg.sv =====
// Shared types and constants for the sparse polynomial adder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  localparam int MAX_TERMS = 32;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_RUN    = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] coef;
    logic signed [15:0] expo;
  } spa_in_t;

  typedef struct packed {
    logic signed [31:0] sum_coef;
    logic signed [15:0] sum_expo;
    logic               term_valid;
    logic               last;
  } spa_out_t;

  typedef struct packed {
    logic signed [31:0] coef;
    logic signed [15:0] expo;
  } term_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_MARK
  } spa_state_e;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic emit_term;
    logic emit_mark;
  } spa_cmd_t;

  typedef struct packed {
    logic both_empty;
    logic out_free;
    logic run_done;
  } spa_status_t;

endpackage

`default_nettype wire

// ===== sv/spa_ctrl.sv =====
// Sequencer for the sparse polynomial adder: decodes requests and steps the merge.
// Depends on spa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spa_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire [1:0]           req_type_i,
  input  spa_pkg::spa_status_t status_i,
  output logic                in_stall_o,
  output spa_pkg::spa_cmd_t   cmd_o
);
  import spa_pkg::*;

  spa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (req_type_i == REQ_RUN)) begin
          state_d = status_i.both_empty ? ST_MARK : ST_READ;
        end
      end
      ST_READ: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.run_done ? ST_IDLE : ST_READ;
        end
      end
      ST_MARK: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_a = in_valid_i && (req_type_i == REQ_LOAD_A);
        cmd_o.load_b = in_valid_i && (req_type_i == REQ_LOAD_B);
      end
      ST_READ: ;
      ST_EMIT: cmd_o.emit_term = status_i.out_free;
      ST_MARK: cmd_o.emit_mark = status_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/spa_datapath.sv =====
// Term stores, counts, merge indexes, head compare, saturating add and result register.
// Depends on spa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spa_datapath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  spa_pkg::spa_in_t     in_data_i,
  input  spa_pkg::spa_cmd_t    cmd_i,
  output spa_pkg::spa_status_t status_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output spa_pkg::spa_out_t    out_data_o
);
  import spa_pkg::*;

  term_t mem_a_q [MAX_TERMS];
  term_t mem_b_q [MAX_TERMS];
  term_t rd_a_q, rd_b_q;

  logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
  logic [CNT_W-1:0] i_q, j_q, i_d, j_d;
  logic             out_valid_q;
  spa_out_t         out_q;

  logic               a_more, b_more, take_a, take_b, run_done, out_free;
  logic signed [32:0] wide_sum;
  logic signed [31:0] sat_sum, term_coef;
  logic signed [15:0] term_expo;
  term_t              new_term;

  assign new_term.coef = in_data_i.coef;
  assign new_term.expo = in_data_i.expo;

  // Stores: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && (cnt_a_q < CNT_W'(MAX_TERMS))) begin
      mem_a_q[cnt_a_q[IDX_W-1:0]] <= new_term;
    end
    if (cmd_i.load_b && (cnt_b_q < CNT_W'(MAX_TERMS))) begin
      mem_b_q[cnt_b_q[IDX_W-1:0]] <= new_term;
    end
    rd_a_q <= mem_a_q[i_q[IDX_W-1:0]];
    rd_b_q <= mem_b_q[j_q[IDX_W-1:0]];
  end

  // Head compare: equal exponents take both.
  assign a_more = (i_q < cnt_a_q);
  assign b_more = (j_q < cnt_b_q);
  assign take_a = a_more && (!b_more || (rd_a_q.expo >= rd_b_q.expo));
  assign take_b = b_more && (!a_more || (rd_b_q.expo >= rd_a_q.expo));
  assign i_d    = i_q + CNT_W'(take_a);
  assign j_d    = j_q + CNT_W'(take_b);
  assign run_done = (i_d == cnt_a_q) && (j_d == cnt_b_q);

  assign wide_sum = {rd_a_q.coef[31], rd_a_q.coef} + {rd_b_q.coef[31], rd_b_q.coef};
  always_comb begin
    if (wide_sum[32] != wide_sum[31]) begin
      sat_sum = wide_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sum = wide_sum[31:0];
    end
  end

  always_comb begin
    if (take_a && take_b) begin
      term_coef = sat_sum;
    end else if (take_a) begin
      term_coef = rd_a_q.coef;
    end else begin
      term_coef = rd_b_q.coef;
    end
    term_expo = take_a ? rd_a_q.expo : rd_b_q.expo;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_a && (cnt_a_q < CNT_W'(MAX_TERMS))) begin
        cnt_a_q <= cnt_a_q + CNT_W'(1);
      end
      if (cmd_i.load_b && (cnt_b_q < CNT_W'(MAX_TERMS))) begin
        cnt_b_q <= cnt_b_q + CNT_W'(1);
      end
      if (cmd_i.emit_term) begin
        if (run_done) begin
          cnt_a_q <= '0;
          cnt_b_q <= '0;
          i_q     <= '0;
          j_q     <= '0;
        end else begin
          i_q <= i_d;
          j_q <= j_d;
        end
      end
      if (cmd_i.emit_term || cmd_i.emit_mark) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_term) begin
      out_q.sum_coef   <= term_coef;
      out_q.sum_expo   <= term_expo;
      out_q.term_valid <= 1'b1;
      out_q.last       <= run_done;
    end else if (cmd_i.emit_mark) begin
      out_q.sum_coef   <= '0;
      out_q.sum_expo   <= '0;
      out_q.term_valid <= 1'b0;
      out_q.last       <= 1'b1;
    end
  end

  assign status_o.both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
  assign status_o.out_free   = out_free;
  assign status_o.run_done   = run_done;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;

endmodule

`default_nettype wire

// ===== sv/sparse_polynomial_adder.sv =====
// Sparse polynomial adder. Load requests are taken while idle and produce nothing.
// A run request emits its results one at a time, each through a store read state and then
// a compare-and-emit state that waits while the output is stalled; inputs stall meanwhile.
// With both lists empty a run gives one marker result from a marker state instead.
// Reset clears both term counts and the handshake state; stored terms are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sparse_polynomial_adder (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  spa_pkg::spa_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output spa_pkg::spa_out_t out_data_o
);
  import spa_pkg::*;

  spa_cmd_t    cmd;
  spa_status_t status;

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  spa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sv/spa_checker.sv =====
// Port-level checks for the sparse polynomial adder, bound to the top level.
// Depends on spa_pkg and sparse_polynomial_adder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sparse_polynomial_adder_assert.svh"

module spa_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_stall_o,
  input spa_pkg::spa_in_t  in_data_i,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input spa_pkg::spa_out_t out_data_o
);
  import spa_pkg::*;

  logic run_req;
  assign run_req = in_valid_i && !in_stall_o && (in_data_i.req_type == REQ_RUN);

  `SPA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `SPA_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  `SPA_ASSERT_IMP(a_marker_form, clk_i, rst_ni, out_valid_o && !out_data_o.term_valid, out_data_o.last && (out_data_o.sum_coef == 0) && (out_data_o.sum_expo == 0))
  `SPA_ASSERT_NXT(a_busy_after_run, clk_i, rst_ni, run_req, in_stall_o)

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for sparse_polynomial_adder: a directed table of requests, then
// random load/run sequences, checked against the table's expected results or an in-bench term-merge predictor.
// Depends on spa_pkg and the sparse_polynomial_adder RTL.
`timescale 1ns / 1ps

module testbench;
  import spa_pkg::*;

  localparam logic [1:0]         REQ_UNKNOWN  = 2'd3;
  localparam logic signed [31:0] COEF_MAX     = 32'sh7fff_ffff;
  localparam logic signed [31:0] COEF_MIN     = 32'sh8000_0000;
  localparam int                 RAND_ITEMS   = 300;
  localparam int                 QUIET_AFTER  = 260;
  localparam int                 LONG_HOLD    = 300;
  localparam int                 DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] coef;
    logic [15:0] expo;
    logic [7:0]  reps;     // repeated with coef+k, expo-k
    logic        typed;    // want holds the single expected result
    spa_out_t    want;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  spa_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spa_out_t out_data;

  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;
  int err_count = 0;
  int n_items   = 0;

  // predictor state
  term_t    poly_a [MAX_TERMS];
  term_t    poly_b [MAX_TERMS];
  int       len_a = 0;
  int       len_b = 0;
  spa_out_t merged_terms [$];   // terms of the latest run
  spa_out_t pending_terms [$];  // expected results not yet seen

  sparse_polynomial_adder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? COEF_MIN : COEF_MAX;
    return s[31:0];
  endfunction

  // Update the predicted lists; a run leaves its result terms in merged_terms.
  task automatic predict(input spa_in_t r);
    int       i;
    int       j;
    spa_out_t t;
    merged_terms.delete();
    case (r.req_type)
      REQ_LOAD_A: begin
        if (len_a < MAX_TERMS) begin
          poly_a[len_a] = {r.coef, r.expo};
          len_a++;
        end
      end
      REQ_LOAD_B: begin
        if (len_b < MAX_TERMS) begin
          poly_b[len_b] = {r.coef, r.expo};
          len_b++;
        end
      end
      REQ_RUN: begin
        if (len_a == 0 && len_b == 0) begin
          merged_terms.push_back({32'h0, 16'h0, 1'b0, 1'b1});
        end else begin
          i = 0;
          j = 0;
          // heads compared as stored, no reordering
          while (i < len_a || j < len_b) begin
            if (j >= len_b || (i < len_a &&
                $signed(poly_a[i].expo) > $signed(poly_b[j].expo))) begin
              t = {poly_a[i].coef, poly_a[i].expo, 1'b1, 1'b0};
              i++;
            end else if (i >= len_a || $signed(poly_a[i].expo) < $signed(poly_b[j].expo)) begin
              t = {poly_b[j].coef, poly_b[j].expo, 1'b1, 1'b0};
              j++;
            end else begin
              t = {sat_sum(poly_a[i].coef, poly_b[j].coef), poly_a[i].expo, 1'b1, 1'b0};
              i++;
              j++;
            end
            merged_terms.push_back(t);
          end
          t = merged_terms.pop_back();
          t.last = 1'b1;
          merged_terms.push_back(t);
        end
        len_a = 0;
        len_b = 0;
      end
      default: ;
    endcase
  endtask

  // Offer one request, hold it until accepted, then log what it should produce.
  task automatic send_item(input spa_in_t req, input bit typed, input spa_out_t want,
                           input bit counted);
    bit taken;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    predict(req);
    if (typed) pending_terms.push_back(want);
    else foreach (merged_terms[k]) pending_terms.push_back(merged_terms[k]);
    if (counted) n_items++;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return COEF_MAX - $urandom_range(0, 3);
      1:       return COEF_MIN + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic dir_row_t row(input logic [1:0] req, input logic [31:0] coef,
                                   input logic [15:0] expo, input int reps, input bit typed,
                                   input spa_out_t want);
    return {req, coef, expo, reps[7:0], typed, want};
  endfunction

  // One polynomial pair: descending exponents drawn from a shared stream so that
  // equal exponents show up, loads of A and B interleaved with stray unknown requests, then a run.
  task automatic random_sequence(input bit big, input bit hold_rx);
    spa_in_t loads_a [$];
    spa_in_t loads_b [$];
    spa_in_t it;
    int      want_a;
    int      want_b;
    int      got_a;
    int      got_b;
    int      e;
    int      pick;
    if (big) begin
      want_a = $urandom_range(26, 36);
      want_b = $urandom_range(26, 36);
    end else begin
      want_a = $urandom_range(0, 6);
      want_b = $urandom_range(0, 6);
    end
    e = int'($urandom_range(0, 65235)) - 32468;
    got_a = 0;
    got_b = 0;
    while (got_a < want_a || got_b < want_b) begin
      if (got_a < want_a && got_b < want_b) pick = $urandom_range(0, 2);
      else pick = (got_a < want_a) ? 0 : 1;
      it.expo = e[15:0];
      if (pick != 1) begin
        it.req_type = REQ_LOAD_A;
        it.coef     = rand_coef();
        loads_a.push_back(it);
        got_a++;
      end
      if (pick != 0) begin
        it.req_type = REQ_LOAD_B;
        it.coef     = rand_coef();
        loads_b.push_back(it);
        got_b++;
      end
      e = e - int'($urandom_range(1, 3));
    end
    // now and then break the ordering of list A
    if (loads_a.size() > 1 && $urandom_range(0, 9) == 0) begin
      it = loads_a[0];
      loads_a[0] = loads_a[loads_a.size() - 1];
      loads_a[loads_a.size() - 1] = it;
    end
    while (loads_a.size() > 0 || loads_b.size() > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        it.req_type = REQ_UNKNOWN;
        it.coef     = $urandom;
        it.expo     = 16'($urandom);
        send_item(it, 1'b0, '0, 1'b0);
      end
      if (loads_b.size() == 0 || (loads_a.size() > 0 && $urandom_range(0, 1) == 1))
        it = loads_a.pop_front();
      else
        it = loads_b.pop_front();
      send_item(it, 1'b0, '0, 1'b1);
    end
    if (hold_rx) hold_req = 1'b1;
    it.req_type = REQ_RUN;
    it.coef     = $urandom;
    it.expo     = 16'($urandom);
    send_item(it, 1'b0, '0, 1'b1);
  endtask

  initial begin
    dir_row_t rows [$];
    spa_in_t  it;
    int       seq;

    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b1, {32'h0, 16'h0, 1'b0, 1'b1}));  // both empty
    rows.push_back(row(REQ_LOAD_A, COEF_MAX, 16'h7fff, 1, 1'b0, '0));
    rows.push_back(row(REQ_LOAD_B, COEF_MAX, 16'h7fff, 1, 1'b0, '0));
    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b1, {COEF_MAX, 16'h7fff, 1'b1, 1'b1}));
    rows.push_back(row(REQ_LOAD_A, COEF_MIN, 16'h8000, 1, 1'b0, '0));
    rows.push_back(row(REQ_LOAD_B, COEF_MIN, 16'h8000, 1, 1'b0, '0));
    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b1, {COEF_MIN, 16'h8000, 1'b1, 1'b1}));
    rows.push_back(row(REQ_LOAD_A, 32'h0005_0000, 16'd3, 1, 1'b0, '0));
    rows.push_back(row(REQ_LOAD_B, 32'hfffb_0000, 16'd3, 1, 1'b0, '0));
    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b1, {32'h0, 16'd3, 1'b1, 1'b1}));     // zero sum
    rows.push_back(row(REQ_UNKNOWN, 32'hffff_ffff, 16'hffff, 1, 1'b0, '0));
    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b1, {32'h0, 16'h0, 1'b0, 1'b1}));
    rows.push_back(row(REQ_LOAD_A, 32'h1234_5678, 16'd100, 1, 1'b0, '0));
    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b1, {32'h1234_5678, 16'd100, 1'b1, 1'b1}));
    rows.push_back(row(REQ_LOAD_B, 32'hffff_ffff, 16'hffff, 1, 1'b0, '0));
    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b1, {32'hffff_ffff, 16'hffff, 1'b1, 1'b1}));
    // one load past capacity on each list
    rows.push_back(row(REQ_LOAD_A, 32'h0001_0000, 16'd40, MAX_TERMS + 1, 1'b0, '0));
    rows.push_back(row(REQ_LOAD_B, 32'hffff_0000, 16'd20, MAX_TERMS + 1, 1'b0, '0));
    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b0, '0));
    // unsorted list A
    rows.push_back(row(REQ_LOAD_A, 32'h0002_0000, 16'd1, 1, 1'b0, '0));
    rows.push_back(row(REQ_LOAD_A, 32'h0003_0000, 16'd5, 1, 1'b0, '0));
    rows.push_back(row(REQ_LOAD_B, 32'h0004_0000, 16'd3, 1, 1'b0, '0));
    rows.push_back(row(REQ_RUN, '0, '0, 1, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      for (int k = 0; k < rows[r].reps; k++) begin
        it.req_type = rows[r].req;
        it.coef     = rows[r].coef + k;
        it.expo     = 16'(rows[r].expo - k);
        send_item(it, rows[r].typed, rows[r].want, rows[r].req != REQ_UNKNOWN);
      end
    end

    seq = 0;
    while (n_items < RAND_ITEMS) begin
      if (seq % 8 == 7) begin
        // sender holds off until the block has drained
        in_valid <= 1'b0;
        wait (pending_terms.size() == 0);
        @(posedge clk);
      end
      random_sequence(seq == 3 || $urandom_range(0, 9) == 0, seq == 3);
      seq++;
      if (n_items >= QUIET_AFTER) quiet = 1'b1;
    end

    in_valid <= 1'b0;
    wait (pending_terms.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side stall pattern
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 29) == 0) begin
        out_stall <= 1'b0;
        repeat (40) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // sample mid-cycle; a result seen here is taken at the next rising edge
  always @(negedge clk) begin
    spa_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_terms.size() == 0) begin
        flag_error($sformatf("unexpected result %h", out_data));
      end else begin
        want = pending_terms.pop_front();
        check_field("sum_coef", 32'(out_data.sum_coef), 32'(want.sum_coef));
        check_field("sum_expo", 32'(out_data.sum_expo), 32'(want.sum_expo));
        check_field("term_valid", 32'(out_data.term_valid), 32'(want.term_valid));
        check_field("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

endmodule
